### sv/tpss_pkg.sv
// Shared types and constants for the text page splitter and selector.
package tpss_pkg;

  // Fixed field widths
  localparam int PAGE_BITS     = 16;
  localparam int LENGTH_BITS   = 24;
  localparam int POS_BITS      = 32;
  localparam int LINE_BITS     = 10;
  localparam int SLOT_BITS     = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 10;

  // Output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // Character codes
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_P  = 8'h70;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;

  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  // Opcodes
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_RANGE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_LINES_PER_PAGE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PARITY_SELECT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TYPESETTER     = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } parse_phase_t;

  typedef struct packed {
    logic                   opcode;
    logic [7:0]             data_byte;
    logic                   end_of_input;
    logic [SLOT_BITS-1:0]   range_slot;
    logic [PAGE_BITS-1:0]   range_low;
    logic [PAGE_BITS-1:0]   range_high;
    logic                   range_on_ordinal;
    logic                   range_valid;
  } in_item_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0]   page_number;
    logic [PAGE_BITS-1:0]   page_ordinal;
    logic [LENGTH_BITS-1:0] page_length;
    logic [POS_BITS-1:0]    input_offset;
    logic [POS_BITS-1:0]    output_offset;
    logic                   selected;
    logic                   last_of_run;
  } out_item_t;

  // Splitter state
  typedef struct packed {
    logic [LINE_BITS-1:0]   line_cnt;
    logic                   pend;
    logic [LENGTH_BITS-1:0] len;
    logic [POS_BITS-1:0]    in_pos;
    logic [POS_BITS-1:0]    pstart;
    logic [PAGE_BITS-1:0]   num;
    logic [PAGE_BITS-1:0]   ord;
    parse_phase_t           phase;
    logic [PAGE_BITS-1:0]   acc;
  } split_st_t;

  // One closed page on its way to selection
  typedef struct packed {
    logic [PAGE_BITS-1:0]   num;
    logic [PAGE_BITS-1:0]   ord;
    logic [LENGTH_BITS-1:0] len;
    logic [POS_BITS-1:0]    start;
    logic [POS_BITS-1:0]    span;
  } page_rec_t;

  typedef struct packed {
    logic num_hit;
    logic ord_hit;
  } lane_hit_t;

  // Token passed along the range cell chain
  typedef struct packed {
    logic                 wr;
    logic [SLOT_BITS-1:0] slot;
    logic [PAGE_BITS-1:0] lo;
    logic [PAGE_BITS-1:0] hi;
    logic                 on_ord;
    logic                 ent_valid;
    logic                 v0;
    logic                 v1;
    logic                 any;
    lane_hit_t            h0;
    lane_hit_t            h1;
    page_rec_t            r0;
    page_rec_t            r1;
  } chain_tok_t;

endpackage

### sv/text_page_splitter_selector_core.sv
// Top level of the text page splitter and selector: config registers and cell chain.
//
//  channel  direction  handshake         payload
//  in_      input      in_valid/in_stall  in_item_t (one text byte or range entry write)
//  out_     output     out_valid/out_stall out_item_t (one page record)
//  cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data (register write)
//
// One item is accepted per cycle while in_stall is low. A page record passes
// through the range cell chain, one cell per table entry, and then the output queue.
// A byte can close two pages; the output queue drains one record per cycle while
// out_stall is low, and in_stall is high while the queue holds more than two records.
// Synchronous reset clears the range table at once; no clearing pass follows.
module text_page_splitter_selector_core import tpss_pkg::*; #(
  parameter int RANGE_ENTRIES = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic [LINE_BITS-1:0] lpp_r;
  logic [1:0]           par_r;
  logic                 ts_r;
  logic                 adv, accept;
  chain_tok_t           tok_w [RANGE_ENTRIES+1];

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpp_r <= LINE_BITS'(66);
      par_r <= '0;
      ts_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LINES_PER_PAGE: lpp_r <= cfg_data[LINE_BITS-1:0];
        CFG_PARITY_SELECT:  par_r <= cfg_data[1:0];
        CFG_TYPESETTER:     ts_r  <= cfg_data[0];
        default:            ;
      endcase
    end
  end

  assign in_stall = !adv;
  assign accept   = in_valid && !in_stall;

  tpss_splitter u_split (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .item           (in_data),
    .lines_per_page (lpp_r),
    .typesetter     (ts_r),
    .tok_o          (tok_w[0])
  );

  // Range cell chain
  for (genvar i = 0; i < RANGE_ENTRIES; i++) begin : g_cell
    tpss_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (tok_w[i]),
      .tok_o (tok_w[i+1])
    );
  end

  tpss_select u_sel (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_i      (tok_w[RANGE_ENTRIES]),
    .parity_sel (par_r),
    .adv        (adv),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

### sv/tpss_splitter.sv
// Page splitter: cuts the byte stream into pages, emits up to two closed pages per item.
module tpss_splitter import tpss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  in_item_t             item,
  input  logic [LINE_BITS-1:0] lines_per_page,
  input  logic                 typesetter,
  output chain_tok_t           tok_o
);

  typedef struct packed {
    split_st_t st;
    page_rec_t rec;
  } close_res_t;

  split_st_t  st_r, st_nxt;
  split_st_t  s;
  close_res_t cr;
  page_rec_t  r0, r1;
  logic       v0, v1, skip, first;
  logic [7:0] b;
  logic [PAGE_BITS+3:0] prod;

  function automatic logic [PAGE_BITS-1:0] sat_inc(input logic [PAGE_BITS-1:0] v);
    sat_inc = (v == '1) ? v : v + PAGE_BITS'(1);
  endfunction

  function automatic split_st_t append(input split_st_t si);
    split_st_t so;
    so = si;
    if (si.len != '1) so.len = si.len + LENGTH_BITS'(1);
    so.in_pos = si.in_pos + POS_BITS'(1);
    append = so;
  endfunction

  // Close the open page: build its record and reset per-page state
  function automatic close_res_t close_pg(input split_st_t si, input logic ts);
    close_res_t res;
    res.st = si;
    if (ts) begin
      res.rec.num = si.num;
      res.rec.ord = si.ord;
    end else begin
      res.st.num  = sat_inc(si.num);
      res.rec.num = res.st.num;
      res.rec.ord = sat_inc(si.ord);
    end
    res.st.ord    = sat_inc(si.ord);
    res.rec.len   = si.len;
    res.rec.start = si.pstart;
    res.rec.span  = si.in_pos - si.pstart;
    res.st.pstart   = si.in_pos;
    res.st.len      = '0;
    res.st.line_cnt = '0;
    res.st.pend     = 1'b0;
    res.st.phase    = PH_IDLE;
    res.st.acc      = '0;
    close_pg = res;
  endfunction

  assign b = item.data_byte;

  // Byte processing
  always_comb begin
    s     = st_r;
    cr    = '0;
    r0    = '0;
    r1    = '0;
    v0    = 1'b0;
    v1    = 1'b0;
    skip  = 1'b0;
    first = 1'b0;
    prod  = '0;

    // page close held back from the previous newline
    if (s.pend) begin
      s.pend = 1'b0;
      if (typesetter) begin
        if (b == CH_P) begin
          cr = close_pg(s, typesetter);
          s  = cr.st;
          r0 = cr.rec;
          v0 = 1'b1;
        end
      end else if (b == CH_FF) begin
        s    = append(s);
        cr   = close_pg(s, typesetter);
        s    = cr.st;
        r0   = cr.rec;
        v0   = 1'b1;
        skip = 1'b1;
      end else begin
        cr = close_pg(s, typesetter);
        s  = cr.st;
        r0 = cr.rec;
        v0 = 1'b1;
      end
    end

    if (!skip) begin
      first = (s.len == '0);
      s     = append(s);
      if (typesetter) begin
        // page number parse after a leading p
        if (first && b == CH_P) begin
          s.phase = PH_DIGITS;
          s.acc   = '0;
        end else if (s.phase == PH_DIGITS) begin
          if (b >= CH_0 && b <= CH_9) begin
            prod = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + {{PAGE_BITS{1'b0}}, b[3:0]};
            s.acc = (prod > {4'b0, {PAGE_BITS{1'b1}}}) ? '1 : prod[PAGE_BITS-1:0];
          end else begin
            s.phase = PH_DONE;
          end
        end
        if (b == CH_NL) begin
          if (s.line_cnt == '0 && s.phase != PH_IDLE) s.num = s.acc;
          s.phase = PH_IDLE;
          if (s.line_cnt != LINE_MAX) s.line_cnt = s.line_cnt + LINE_BITS'(1);
          s.pend = 1'b1;
        end
      end else begin
        if (b == CH_FF) begin
          cr = close_pg(s, typesetter);
          s  = cr.st;
          if (!v0) begin
            r0 = cr.rec;
            v0 = 1'b1;
          end else begin
            r1 = cr.rec;
            v1 = 1'b1;
          end
        end else if (b == CH_NL) begin
          if (s.line_cnt != LINE_MAX) s.line_cnt = s.line_cnt + LINE_BITS'(1);
          if (s.line_cnt >= lines_per_page) s.pend = 1'b1;
        end
      end
    end

    // end of input closes a non-empty page
    if (item.end_of_input && s.len != '0) begin
      cr = close_pg(s, typesetter);
      s  = cr.st;
      if (!v0) begin
        r0 = cr.rec;
        v0 = 1'b1;
      end else begin
        r1 = cr.rec;
        v1 = 1'b1;
      end
    end
  end

  assign st_nxt = (accept && item.opcode == OP_DATA) ? s : st_r;

  // Token into the cell chain
  always_comb begin
    tok_o           = '0;
    tok_o.wr        = accept && item.opcode == OP_RANGE;
    tok_o.slot      = item.range_slot;
    tok_o.lo        = item.range_low;
    tok_o.hi        = item.range_high;
    tok_o.on_ord    = item.range_on_ordinal;
    tok_o.ent_valid = item.range_valid;
    tok_o.v0        = accept && item.opcode == OP_DATA && v0;
    tok_o.v1        = accept && item.opcode == OP_DATA && v1;
    tok_o.r0        = r0;
    tok_o.r1        = r1;
  end

  // all-zero state is idle parse phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

### sv/tpss_cell.sv
// Range cell: holds one range table entry and marks hits on pages passing by.
module tpss_cell import tpss_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  chain_tok_t tok_i,
  output chain_tok_t tok_o
);

  logic [PAGE_BITS-1:0] lo_r, hi_r;
  logic                 on_ord_r, valid_r;
  chain_tok_t           tok_r, tok_nxt;
  logic                 hit_slot;

  assign hit_slot = (int'(tok_i.slot) == IDX);

  // Compare both page lanes against this entry
  always_comb begin
    tok_nxt = tok_i;
    if (valid_r) begin
      tok_nxt.any = 1'b1;
      if (on_ord_r) begin
        if (lo_r <= tok_i.r0.ord && tok_i.r0.ord <= hi_r) tok_nxt.h0.ord_hit = 1'b1;
        if (lo_r <= tok_i.r1.ord && tok_i.r1.ord <= hi_r) tok_nxt.h1.ord_hit = 1'b1;
      end else begin
        if (lo_r <= tok_i.r0.num && tok_i.r0.num <= hi_r) tok_nxt.h0.num_hit = 1'b1;
        if (lo_r <= tok_i.r1.num && tok_i.r1.num <= hi_r) tok_nxt.h1.num_hit = 1'b1;
      end
    end
  end

  // Token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  // Entry write when the write item reaches this cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv && tok_i.wr && hit_slot) begin
      valid_r <= tok_i.ent_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok_i.wr && hit_slot) begin
      lo_r     <= tok_i.lo;
      hi_r     <= tok_i.hi;
      on_ord_r <= tok_i.on_ord;
    end
  end

  assign tok_o = tok_r;

endmodule

### sv/tpss_select.sv
// Page selector: keep decision, output offsets and the result item queue.
module tpss_select import tpss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  chain_tok_t tok_i,
  input  logic [1:0] parity_sel,
  output logic       adv,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  localparam logic [1:0] PAR_EVEN = 2'd1;
  localparam logic [1:0] PAR_ODD  = 2'd2;

  out_item_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   cnt_r, cnt_nxt;
  logic [POS_BITS-1:0]  kept_r, kept_nxt, kept_mid;
  logic                 sel0, sel1, pop;
  logic [FIFO_CW-1:0]   push_n;
  out_item_t            o0, o1;

  function automatic logic par_ok(input logic [1:0] ps, input logic [PAGE_BITS-1:0] v);
    case (ps)
      PAR_EVEN: par_ok = !v[0];
      PAR_ODD:  par_ok = v[0];
      default:  par_ok = 1'b1;
    endcase
  endfunction

  function automatic logic keep(input logic [1:0] ps, input logic any, input lane_hit_t h,
                                input page_rec_t r);
    if (r.ord == '0)
      keep = 1'b1;
    else if (any)
      keep = (h.num_hit && par_ok(ps, r.num)) || (h.ord_hit && par_ok(ps, r.ord));
    else
      keep = par_ok(ps, r.num);
  endfunction

  // Room for two items keeps the chain moving
  assign adv = (cnt_r <= FIFO_CW'(FIFO_DEPTH - 2));

  // Keep flags and running kept-byte offset
  always_comb begin
    sel0     = keep(parity_sel, tok_i.any, tok_i.h0, tok_i.r0);
    sel1     = keep(parity_sel, tok_i.any, tok_i.h1, tok_i.r1);
    kept_mid = kept_r + ((tok_i.v0 && sel0) ? tok_i.r0.span : '0);
    kept_nxt = kept_mid + ((tok_i.v1 && sel1) ? tok_i.r1.span : '0);
    if (!adv) kept_nxt = kept_r;

    o0.page_number   = tok_i.r0.num;
    o0.page_ordinal  = tok_i.r0.ord;
    o0.page_length   = tok_i.r0.len;
    o0.input_offset  = tok_i.r0.start;
    o0.output_offset = kept_r;
    o0.selected      = sel0;
    o0.last_of_run   = !tok_i.v1;

    o1.page_number   = tok_i.r1.num;
    o1.page_ordinal  = tok_i.r1.ord;
    o1.page_length   = tok_i.r1.len;
    o1.input_offset  = tok_i.r1.start;
    o1.output_offset = kept_mid;
    o1.selected      = sel1;
    o1.last_of_run   = 1'b1;
  end

  // Queue pointers
  always_comb begin
    pop        = out_valid && !out_stall;
    push_n     = adv ? (FIFO_CW'(tok_i.v0) + FIFO_CW'(tok_i.v1)) : '0;
    wr_ptr_nxt = wr_ptr_r + push_n[FIFO_AW-1:0];
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    cnt_nxt    = cnt_r + push_n - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      kept_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      kept_r   <= kept_nxt;
    end
  end

  // Queue storage; lane 0 first
  always_ff @(posedge clk) begin
    if (adv && tok_i.v0) mem[wr_ptr_r] <= o0;
    if (adv && tok_i.v1) mem[wr_ptr_r + FIFO_AW'(1)] <= o1;
  end

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rd_ptr_r];

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the text page splitter and selector core.
module tb import tpss_pkg::*;;

  localparam int TABLE_SLOTS   = 8;
  // a record trails its closing byte by the cell chain; leave room for two
  localparam int SETTLE_CYCLES = 2 * (TABLE_SLOTS + 1) + 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SEG_ITEMS     = 88;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // idle / stall percentages and receiver hold-off
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int items_sent = 0;
  int mismatches = 0;
  int cycle_cnt = 0;

  // page records still owed by the block, oldest first
  out_item_t pending_pages[$];

  // mirror of the block's registers and state
  logic [LINE_BITS-1:0]   lpp = 10'd66;
  logic [1:0]             par_sel = 2'd0;
  logic                   ts_mode = 1'b0;
  logic [LINE_BITS-1:0]   line_cnt = '0;
  logic                   close_pend = 1'b0;
  logic [LENGTH_BITS-1:0] cur_len = '0;
  logic [POS_BITS-1:0]    in_pos = '0;
  logic [POS_BITS-1:0]    kept_pos = '0;
  logic [POS_BITS-1:0]    pg_start = '0;
  logic [PAGE_BITS-1:0]   cur_num = '0;
  logic [PAGE_BITS-1:0]   cur_ord = '0;
  parse_phase_t           phase = PH_IDLE;
  logic [PAGE_BITS-1:0]   acc = '0;
  logic [PAGE_BITS-1:0]   rng_lo [TABLE_SLOTS];
  logic [PAGE_BITS-1:0]   rng_hi [TABLE_SLOTS];
  logic                   rng_on_ord [TABLE_SLOTS];
  logic                   rng_valid [TABLE_SLOTS] = '{default: 1'b0};

  text_page_splitter_selector_core #(.RANGE_ENTRIES(TABLE_SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // receiver: long hold-off when requested, else random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------- page prediction ----------------

  function automatic logic [PAGE_BITS-1:0] sat_inc(logic [PAGE_BITS-1:0] v);
    return (v == '1) ? v : v + PAGE_BITS'(1);
  endfunction

  function automatic bit parity_pass(logic [PAGE_BITS-1:0] v);
    if (par_sel == 2'd1) return !v[0];
    if (par_sel == 2'd2) return v[0];
    return 1'b1;
  endfunction

  // prologue always kept; table decides when any entry is live
  function automatic bit page_kept(logic [PAGE_BITS-1:0] num, logic [PAGE_BITS-1:0] ord);
    bit any = 1'b0;
    bit num_hit = 1'b0;
    bit ord_hit = 1'b0;
    if (ord == '0) return 1'b1;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (rng_valid[i]) begin
        any = 1'b1;
        if (rng_on_ord[i]) begin
          if (rng_lo[i] <= ord && ord <= rng_hi[i]) ord_hit = 1'b1;
        end else begin
          if (rng_lo[i] <= num && num <= rng_hi[i]) num_hit = 1'b1;
        end
      end
    end
    if (any) return (num_hit && parity_pass(num)) || (ord_hit && parity_pass(ord));
    return parity_pass(num);
  endfunction

  function automatic void add_byte();
    if (cur_len != '1) cur_len = cur_len + LENGTH_BITS'(1);
    in_pos = in_pos + POS_BITS'(1);
  endfunction

  task automatic close_page(output out_item_t rec);
    logic [PAGE_BITS-1:0] num;
    logic [PAGE_BITS-1:0] ord;
    logic [POS_BITS-1:0]  span;
    bit keep;
    if (ts_mode) begin
      num = cur_num;
      ord = cur_ord;
    end else begin
      cur_num = sat_inc(cur_num);
      num = cur_num;
      ord = sat_inc(cur_ord);
    end
    cur_ord = sat_inc(cur_ord);
    keep = page_kept(num, ord);
    span = in_pos - pg_start;
    rec.page_number   = num;
    rec.page_ordinal  = ord;
    rec.page_length   = cur_len;
    rec.input_offset  = pg_start;
    rec.output_offset = kept_pos;
    rec.selected      = keep;
    rec.last_of_run   = 1'b0;
    // kept bytes advance by the true span, not the saturated length
    if (keep) kept_pos = kept_pos + span;
    pg_start   = in_pos;
    cur_len    = '0;
    line_cnt   = '0;
    close_pend = 1'b0;
    phase      = PH_IDLE;
    acc        = '0;
  endtask

  task automatic predict_pages(in_item_t it);
    out_item_t recs[$];
    out_item_t rec;
    logic [7:0] b;
    logic [31:0] v;
    bit first;
    bit absorbed;
    if (it.opcode == OP_RANGE) begin
      rng_lo[it.range_slot]     = it.range_low;
      rng_hi[it.range_slot]     = it.range_high;
      rng_on_ord[it.range_slot] = it.range_on_ordinal;
      rng_valid[it.range_slot]  = it.range_valid;
      return;
    end
    b = it.data_byte;
    absorbed = 1'b0;
    // a page waiting on its next byte
    if (close_pend) begin
      close_pend = 1'b0;
      if (ts_mode) begin
        if (b == CH_P) begin
          close_page(rec);
          recs.push_back(rec);
        end
      end else if (b == CH_FF) begin
        add_byte();
        close_page(rec);
        recs.push_back(rec);
        absorbed = 1'b1;
      end else begin
        close_page(rec);
        recs.push_back(rec);
      end
    end
    if (!absorbed) begin
      first = (cur_len == '0);
      add_byte();
      if (ts_mode) begin
        // page number digits after a leading p
        if (first && b == CH_P) begin
          phase = PH_DIGITS;
          acc = '0;
        end else if (phase == PH_DIGITS) begin
          if (b >= CH_0 && b <= CH_9) begin
            v = 32'(acc) * 32'd10 + 32'(b - CH_0);
            acc = (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
          end else begin
            phase = PH_DONE;
          end
        end
        if (b == CH_NL) begin
          if (line_cnt == '0 && phase != PH_IDLE) cur_num = acc;
          phase = PH_IDLE;
          if (line_cnt != LINE_MAX) line_cnt = line_cnt + LINE_BITS'(1);
          close_pend = 1'b1;
        end
      end else begin
        if (b == CH_FF) begin
          close_page(rec);
          recs.push_back(rec);
        end else if (b == CH_NL) begin
          if (line_cnt != LINE_MAX) line_cnt = line_cnt + LINE_BITS'(1);
          if (line_cnt >= lpp) close_pend = 1'b1;
        end
      end
    end
    if (it.end_of_input && cur_len != '0) begin
      close_page(rec);
      recs.push_back(rec);
    end
    if (recs.size() > 0) recs[recs.size()-1].last_of_run = 1'b1;
    foreach (recs[i]) pending_pages.push_back(recs[i]);
  endtask

  // ---------------- result checking ----------------

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %0h got %0h", what, want, got);
  endtask

  task automatic cmp_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) flag_mismatch(what, want, got);
  endtask

  always @(posedge clk) begin : check_pages
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pages.size() == 0) begin
        flag_mismatch("record with none owed, page_number", 32'd0, 32'(out_data.page_number));
      end else begin
        want = pending_pages.pop_front();
        cmp_field("page_number", 32'(want.page_number), 32'(out_data.page_number));
        cmp_field("page_ordinal", 32'(want.page_ordinal), 32'(out_data.page_ordinal));
        cmp_field("page_length", 32'(want.page_length), 32'(out_data.page_length));
        cmp_field("input_offset", want.input_offset, out_data.input_offset);
        cmp_field("output_offset", want.output_offset, out_data.output_offset);
        cmp_field("selected", 32'(want.selected), 32'(out_data.selected));
        cmp_field("last_of_run", 32'(want.last_of_run), 32'(out_data.last_of_run));
      end
    end
  end

  // ---------------- drivers ----------------

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pages(it);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic in_item_t text_item(logic [7:0] b, bit eoi);
    in_item_t it;
    it.opcode           = OP_DATA;
    it.data_byte        = b;
    it.end_of_input     = eoi;
    it.range_slot       = 3'($urandom);
    it.range_low        = 16'($urandom);
    it.range_high       = 16'($urandom);
    it.range_on_ordinal = 1'($urandom);
    it.range_valid      = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t range_item(logic [SLOT_BITS-1:0] slot, logic [PAGE_BITS-1:0] lo,
                                          logic [PAGE_BITS-1:0] hi, bit on_ord, bit ent_valid);
    in_item_t it;
    it.opcode           = OP_RANGE;
    it.data_byte        = 8'($urandom);
    it.end_of_input     = 1'($urandom);
    it.range_slot       = slot;
    it.range_low        = lo;
    it.range_high       = hi;
    it.range_on_ordinal = on_ord;
    it.range_valid      = ent_valid;
    return it;
  endfunction

  // open, empty, wide and narrow ranges near the page numbers in use
  function automatic in_item_t rand_range_item();
    logic [PAGE_BITS-1:0] lo;
    logic [PAGE_BITS-1:0] hi;
    case ($urandom_range(9))
      0: begin lo = '0; hi = '1; end
      1: begin lo = 16'($urandom_range(1, 65535)); hi = lo - 16'd1; end
      2: begin lo = 16'($urandom); hi = 16'($urandom); end
      default: begin
        lo = 16'($urandom_range(0, 300));
        hi = lo + 16'($urandom_range(0, 60));
      end
    endcase
    return range_item(3'($urandom), lo, hi, 1'($urandom), $urandom_range(9) < 7);
  endfunction

  task automatic send_byte(logic [7:0] b, bit eoi);
    send_item(text_item(b, eoi));
  endtask

  // cfg writes; cfg_valid stays high between back-to-back writes
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_LINES_PER_PAGE: lpp = val;
      CFG_PARITY_SELECT:  par_sel = val[1:0];
      CFG_TYPESETTER:     ts_mode = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // upper data bits of the narrow registers are noise
  task automatic set_config(logic [LINE_BITS-1:0] lines, logic [1:0] parity, bit mode);
    write_reg(CFG_LINES_PER_PAGE, lines);
    write_reg(CFG_PARITY_SELECT, {8'($urandom), parity});
    write_reg(CFG_TYPESETTER, {9'($urandom), mode});
    cfg_valid <= 1'b0;
  endtask

  // stop sending, wait for every owed record, then let the chain empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pages.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------- stimulus sources ----------------

  function automatic logic [7:0] line_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_NL || b == CH_P);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(4))
      0: return CH_P;
      1: return CH_NL;
      2: return CH_FF;
      3: return CH_0 + 8'($urandom_range(9));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] plain_byte();
    int r;
    r = $urandom_range(99);
    if (r < 8) return CH_FF;
    if (r < 28) return CH_NL;
    if (r < 32) return CH_P;
    return 8'($urandom);
  endfunction

  // well-formed typesetter page: p, digits, optional tail, then body lines
  task automatic send_ts_page();
    int ndig;
    int nlines;
    int len;
    send_byte(CH_P, 1'b0);
    ndig = $urandom_range(0, 6);
    repeat (ndig) send_byte(CH_0 + 8'($urandom_range(9)), 1'b0);
    if ($urandom_range(3) == 0) send_byte(line_byte(), 1'b0);
    send_byte(CH_NL, 1'b0);
    nlines = $urandom_range(0, 3);
    repeat (nlines) begin
      len = $urandom_range(0, 4);
      repeat (len) send_byte(line_byte(), 1'b0);
      send_byte(CH_NL, $urandom_range(19) == 0);
    end
  endtask

  // ---------------- tests ----------------

  // prologue, digit saturation, number-less page, end of input
  task automatic test_typesetter_directed();
    write_reg(CFG_UNUSED, 10'($urandom));
    set_config(10'd66, 2'd2, 1'b1);
    send_byte("x", 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_P, 1'b0);
    repeat (5) send_byte(CH_9, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_P, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_P, 1'b0);
    send_byte("7", 1'b0);
    send_byte("z", 1'b0);
    send_byte(CH_NL, 1'b1);
    // leave a page open across the mode change
    send_byte(CH_P, 1'b0);
    send_byte(CH_0, 1'b0);
    wait_drained();
  endtask

  // form feed, line limit, absorbed form feed, empty range, double close
  task automatic test_plain_directed();
    set_config(10'd2, 2'd0, 1'b0);
    send_byte(CH_FF, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_FF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_P, 1'b0);
    send_item(range_item(3'd7, 16'hFFFF, 16'h0000, 1'b0, 1'b1));
    send_byte(8'h00, 1'b1);
    wait_drained();
    // every newline closes; parity code 3 acts as any
    set_config(10'd0, 2'd3, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte("a", 1'b1);
    send_item(range_item(3'd7, 16'h0000, 16'hFFFF, 1'b1, 1'b0));
    wait_drained();
  endtask

  // receiver holds off while the sender keeps two-record bytes coming
  task automatic test_backpressure();
    set_config(10'd1, 2'd0, 1'b0);
    @(posedge clk);
    hold_left = 400;
    @(negedge clk);
    repeat (30) begin
      send_byte(CH_NL, 1'b0);
      send_byte("a", 1'b1);
    end
    wait_drained();
  endtask

  // random streams over every idle mode, both splitting modes
  task automatic test_random_streams();
    int target;
    int r;
    logic [LINE_BITS-1:0] lines;
    logic [1:0] parity;
    for (int seg = 0; seg < 8; seg++) begin
      wait_drained();
      case (seg / 2)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 64; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      if (seg == 0) lines = 10'd1;
      else if (seg == 2) lines = 10'd0;
      else if (seg == 6) lines = 10'd1023;
      else lines = 10'($urandom_range(2, 8));
      parity = (seg < 4) ? 2'(seg) : 2'($urandom_range(3));
      set_config(lines, parity, 1'(seg % 2));
      // sometimes start from an empty table so parity alone decides
      if ($urandom_range(1) == 1) begin
        for (int s = 0; s < TABLE_SLOTS; s++)
          send_item(range_item(3'(s), 16'($urandom), 16'($urandom), 1'($urandom), 1'b0));
      end
      target = items_sent + SEG_ITEMS;
      while (items_sent < target) begin
        r = $urandom_range(99);
        if (seg % 2 == 0) begin
          if (r < 3) send_item(rand_range_item());
          else send_byte(plain_byte(), $urandom_range(49) == 0);
        end else begin
          if (r < 10) begin
            repeat ($urandom_range(1, 4)) send_byte(noise_byte(), $urandom_range(29) == 0);
          end else if (r < 15) begin
            send_item(rand_range_item());
          end else begin
            send_ts_page();
          end
        end
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_typesetter_directed();
    test_plain_directed();
    test_backpressure();
    test_random_streams();
    wait_drained();
    if (mismatches == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
